/* rtl/nrh_pkg.sv */
package nrh_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int COUNT_BITS = 20;
  localparam int CNT_W      = COUNT_BITS + 1;
  localparam int NBINS      = 1 << PIXEL_BITS;
  localparam int FREQ_BITS  = 16;
  localparam int FREQ_W     = FREQ_BITS + 1;
  localparam int RLEN_W     = PIXEL_BITS + 1;

  localparam logic [PIXEL_BITS-1:0] PIX_MAX   = {PIXEL_BITS{1'b1}};
  localparam logic [CNT_W-1:0]      COUNT_MAX = CNT_W'(1) << COUNT_BITS;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]            op;
    logic [PIXEL_BITS-1:0] value;
  } nrh_in_t;

  typedef struct packed {
    logic                  valid_res;
    logic [PIXEL_BITS-1:0] bin_value;
    logic [CNT_W-1:0]      bin_count;
    logic [FREQ_W-1:0]     frequency;
    logic [RLEN_W-1:0]     range_len;
  } nrh_out_t;

endpackage

/* rtl/normalized_range_histogram_unit.sv */
// Histogram of pixel values with reads relative to the smallest value seen. An add
// reads the bin from the 256-entry bin memory in the cycle of the transfer and
// writes it back, incremented and saturated, in the next. A read that falls inside
// the observed range passes through the memory read, the divider load, the
// shift-subtract divider that forms the Q1.16 frequency (one quotient bit per
// cycle) and the hand-over of the result to the output register; a read outside
// the range or on an empty histogram goes straight to the hand-over. Only one item
// is in flight at a time, while a finished result may still wait in the output
// register. The bin memory needs no clearing pass after reset or clear: a valid
// bit per bin marks the entries written since.
module normalized_range_histogram_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  nrh_pkg::nrh_in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output nrh_pkg::nrh_out_t out_data
);
  import nrh_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADD  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam int         DIV_STEPS = FREQ_W;
  localparam int         STEP_W    = $clog2(DIV_STEPS);

  logic [2:0]            state;
  logic [NBINS-1:0]      bin_valid;
  logic [PIXEL_BITS-1:0] low_seen;
  logic [PIXEL_BITS-1:0] high_seen;
  logic [CNT_W-1:0]      pixel_total;
  logic [PIXEL_BITS-1:0] addr;
  logic [CNT_W-1:0]      rd_data;
  logic                  rd_hit;
  logic [CNT_W-1:0]      rem;
  logic [FREQ_W-1:0]     dvd;
  logic [STEP_W-1:0]     step;
  nrh_out_t              res;

  logic [CNT_W-1:0]      bin_mem [NBINS];

  logic                  accept;
  logic [PIXEL_BITS-1:0] span;
  logic                  in_range;
  logic [PIXEL_BITS-1:0] read_idx;
  logic [PIXEL_BITS-1:0] rd_addr;
  logic [CNT_W-1:0]      cur_count;
  logic [CNT_W-1:0]      inc_count;
  logic                  wr_en;
  logic [CNT_W:0]        trial;
  logic                  trial_ge;
  logic [CNT_W-1:0]      rem_next;
  logic                  out_free;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign span      = high_seen - low_seen;
  assign in_range  = (pixel_total != '0) && (in_data.value <= span);
  assign read_idx  = low_seen + in_data.value;
  assign rd_addr   = (in_data.op == OP_ADD) ? in_data.value : read_idx;

  assign cur_count = rd_hit ? rd_data : '0;
  assign inc_count = (cur_count < COUNT_MAX) ? cur_count + CNT_W'(1) : cur_count;
  assign wr_en     = (state == ST_ADD);

  // One restoring division step: the partial remainder always stays below the total.
  assign trial     = {rem, dvd[FREQ_W-1]};
  assign trial_ge  = trial >= {1'b0, pixel_total};
  assign rem_next  = trial_ge ? CNT_W'(trial - {1'b0, pixel_total}) : trial[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bin_mem[addr] <= inc_count;
    end
    if (accept) begin
      rd_data <= bin_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      bin_valid   <= '0;
      low_seen    <= PIX_MAX;
      high_seen   <= '0;
      pixel_total <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (in_data.op)
              OP_CLEAR: begin
                bin_valid   <= '0;
                low_seen    <= PIX_MAX;
                high_seen   <= '0;
                pixel_total <= '0;
              end
              OP_ADD: begin
                if (pixel_total < COUNT_MAX) begin
                  pixel_total <= pixel_total + CNT_W'(1);
                end
                if (in_data.value < low_seen) begin
                  low_seen <= in_data.value;
                end
                if (in_data.value > high_seen) begin
                  high_seen <= in_data.value;
                end
                state <= ST_ADD;
              end
              OP_READ: begin
                state <= in_range ? ST_RD : ST_DONE;
              end
              default: begin
              end
            endcase
          end
        end
        ST_ADD: begin
          bin_valid[addr] <= 1'b1;
          state           <= ST_IDLE;
        end
        ST_RD: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr   <= rd_addr;
      rd_hit <= bin_valid[rd_addr];
      res.valid_res <= in_range;
      res.bin_value <= in_range ? read_idx : '0;
      res.bin_count <= '0;
      res.frequency <= '0;
      res.range_len <= (pixel_total != '0) ? RLEN_W'(span) + RLEN_W'(1) : '0;
    end
    if (state == ST_RD) begin
      // Dividend is count * 2^16; the quotient never needs more than 17 bits.
      res.bin_count <= cur_count;
      rem           <= cur_count >> 1;
      dvd           <= {cur_count[0], {FREQ_BITS{1'b0}}};
      step          <= '0;
    end
    if (state == ST_DIV) begin
      rem  <= rem_next;
      dvd  <= {dvd[FREQ_W-2:0], trial_ge};
      step <= step + STEP_W'(1);
      if (step == STEP_W'(DIV_STEPS - 1)) begin
        res.frequency <= {dvd[FREQ_W-2:0], trial_ge};
      end
    end
    if (state == ST_DONE && out_free) begin
      out_data <= res;
    end
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result register loaded outside the hand-over state");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    pixel_total <= COUNT_MAX)
    else $error("pixel total passed its saturation value");

  a_empty_window: assert property (@(posedge clk) disable iff (rst)
    pixel_total == '0 |-> low_seen == PIX_MAX && high_seen == '0)
    else $error("range window moved without any pixel");

  a_freq_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.valid_res |-> out_data.frequency <= (FREQ_W'(1) << FREQ_BITS))
    else $error("frequency above one");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.valid_res |->
      out_data.bin_count == '0 && out_data.frequency == '0 && out_data.bin_value == '0)
    else $error("invalid read carries nonzero fields");

endmodule
